### rtl/luhn_pkg.sv
// Shared widths, verdict codes and digit-pass status type for the Luhn card check.
`default_nettype none

package luhn_pkg;

  localparam int CARD_W     = 54;               // binary card number width
  localparam int NUM_DIGITS = 17;               // decimal digits a 54-bit value can hold
  localparam int BCD_W      = 4 * NUM_DIGITS;   // packed BCD width
  localparam int IDX_W      = 5;                // digit index / digit count width
  localparam int STEP_W     = 6;                // sequencer step counter width

  localparam logic [1:0] VERDICT_INVALID    = 2'd0;
  localparam logic [1:0] VERDICT_AMEX       = 2'd1;
  localparam logic [1:0] VERDICT_VISA       = 2'd2;
  localparam logic [1:0] VERDICT_MASTERCARD = 2'd3;

  // Status of the digit pass, handed to the sequencer.
  typedef struct packed {
    logic             checksum_ok;
    logic [IDX_W-1:0] count;
    logic [3:0]       lead;
    logic [3:0]       second;
  } luhn_digit_sum_t;

endpackage

`default_nettype wire

### rtl/luhn_card_number_check.sv
// Top level of the Luhn card number check: sequencer, classification and output register.
//
//   channel  | direction | tdata fields (low bit first)
//   ---------+-----------+-----------------------------------------------------------
//   s_*      | in        | card_number[53:0], 2 zero bits
//   m_*      | out       | verdict[1:0], checksum_ok, digit_count[4:0], out_of_range,
//            |           | 7 zero bits
//
// From its transfer, a number goes through bit-serial BCD conversion, then the
// digit pass (one BCD digit a cycle through the Luhn accumulator), then a final
// step that classifies and loads the output register. A new number is taken only
// while the sequencer is idle, so a number is taken only after the previous one
// has passed through every step; the result register lets the next number in
// while the previous result still waits. A stalled m_tready holds the sequencer
// in its final step. Synchronous rst clears the sequencer and the output valid.
`default_nettype none

module luhn_card_number_check
  import luhn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // [53:0] card_number, [55:54] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [1:0] verdict, [2] checksum_ok,
                                      // [7:3] digit_count, [8] out_of_range
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_DIGIT = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;

  logic            s_xfer;
  logic            conv_step;
  logic            digit_step;
  logic            out_load;
  logic [3:0]      digit;
  luhn_digit_sum_t status;

  logic       oor;
  logic [1:0] verdict;

  assign s_tready   = (state == ST_IDLE);
  assign s_xfer     = s_tvalid && s_tready;
  assign conv_step  = (state == ST_CONV);
  assign digit_step = (state == ST_DIGIT);
  assign out_load   = (state == ST_DONE) && (!m_tvalid || m_tready);

  luhn_bcd_conv u_conv (
    .clk        (clk),
    .load       (s_xfer),
    .value      (s_tdata[CARD_W-1:0]),
    .conv_step  (conv_step),
    .digit_step (digit_step),
    .digit      (digit)
  );

  luhn_digit_pass u_pass (
    .clk    (clk),
    .clr    (s_xfer),
    .step   (digit_step),
    .digit  (digit),
    .status (status)
  );

  // sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          state_next = ST_CONV;
          cnt_next   = '0;
        end
      end
      ST_CONV: begin
        if (cnt == STEP_W'(CARD_W - 1)) begin
          state_next = ST_DIGIT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      ST_DIGIT: begin
        if (cnt == STEP_W'(NUM_DIGITS - 1)) begin
          state_next = ST_DONE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // range follows from the digit count: 10 to 16 digits is 10^9 .. 10^16-1
  always_comb begin
    oor     = (status.count < IDX_W'(10)) || (status.count > IDX_W'(16));
    verdict = VERDICT_INVALID;
    if (status.checksum_ok && !oor) begin
      if (status.lead == 4'd3 && (status.second == 4'd4 || status.second == 4'd7) &&
          status.count == IDX_W'(15)) begin
        verdict = VERDICT_AMEX;
      end else if (status.lead == 4'd4 &&
                   (status.count == IDX_W'(13) || status.count == IDX_W'(16))) begin
        verdict = VERDICT_VISA;
      end else if (status.lead == 4'd5 && status.second >= 4'd1 &&
                   status.second <= 4'd5 && status.count == IDX_W'(16)) begin
        verdict = VERDICT_MASTERCARD;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, oor, status.count, status.checksum_ok, verdict};
    end
  end

endmodule

`default_nettype wire

### rtl/luhn_bcd_conv.sv
// Bit-serial binary-to-BCD converter (shift and add-3) with a digit shift-out port.
`default_nettype none

module luhn_bcd_conv
  import luhn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [CARD_W-1:0] value,
  input  wire logic              conv_step,
  input  wire logic              digit_step,
  output logic [3:0]             digit
);

  logic [CARD_W-1:0] bin;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin <= value;
      bcd <= '0;
    end else if (conv_step) begin
      bin <= {bin[CARD_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[CARD_W-1]};
    end else if (digit_step) begin
      bcd <= {4'd0, bcd[BCD_W-1:4]};
    end
  end

  assign digit = bcd[3:0];

endmodule

`default_nettype wire

### rtl/luhn_digit_pass.sv
// Per-digit Luhn accumulator: mod-10 sum, digit count and the two leading digits.
`default_nettype none

module luhn_digit_pass
  import luhn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        clr,
  input  wire logic        step,
  input  wire logic [3:0]  digit,
  output luhn_digit_sum_t  status
);

  logic [IDX_W-1:0] idx;
  logic [3:0]       sum_mod;
  logic [3:0]       prev;
  logic [IDX_W-1:0] count;
  logic [3:0]       lead;
  logic [3:0]       second;

  logic [4:0] dbl;
  logic [4:0] contrib;
  logic [4:0] sum_raw;
  logic [3:0] sum_next;

  always_comb begin
    dbl = {digit, 1'b0};
    // odd positions from the right are doubled; 2d >= 10 folds to 2d - 9
    if (idx[0]) begin
      contrib = (digit >= 4'd5) ? (dbl - 5'd9) : dbl;
    end else begin
      contrib = {1'b0, digit};
    end
    sum_raw = {1'b0, sum_mod} + contrib;
    if (sum_raw >= 5'd10) begin
      sum_next = 4'(sum_raw - 5'd10);
    end else begin
      sum_next = sum_raw[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      idx     <= '0;
      sum_mod <= '0;
      prev    <= '0;
      count   <= '0;
      lead    <= '0;
      second  <= '0;
    end else if (step) begin
      idx     <= idx + IDX_W'(1);
      sum_mod <= sum_next;
      prev    <= digit;
      if (digit != 4'd0) begin
        count  <= idx + IDX_W'(1);
        lead   <= digit;
        second <= prev;
      end
    end
  end

  always_comb begin
    status.checksum_ok = (sum_mod == 4'd0);
    status.count       = count;
    status.lead        = lead;
    status.second      = second;
  end

endmodule

`default_nettype wire

### test/luhn_verdict_checker.sv
// Checker for the Luhn card check: watches both streams, predicts each verdict and compares.
`timescale 1ns / 100ps

module luhn_verdict_checker
  import luhn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  output int          error_count,
  output int          pending,
  output int          checked,
  output int          luhn_passed,
  output int          classified
);

  localparam logic [63:0] LOW_LIMIT  = 64'd1_000_000_000;
  localparam logic [63:0] HIGH_LIMIT = 64'd10_000_000_000_000_000;

  typedef struct packed {
    logic [1:0] verdict;
    logic       checksum_ok;
    logic [4:0] digit_count;
    logic       out_of_range;
  } card_verdict_t;

  typedef struct {
    logic [CARD_W-1:0] number;
    card_verdict_t     result;
  } pending_card_t;

  pending_card_t expected_verdicts[$];

  initial begin
    error_count = 0;
    pending     = 0;
    checked     = 0;
    luhn_passed = 0;
    classified  = 0;
  end

  // Digit-by-digit Luhn sum, least significant digit first; classification
  // only for a passing number in range.
  function automatic card_verdict_t luhn_predict(logic [CARD_W-1:0] number);
    logic [63:0]   rest;
    int unsigned   digit;
    int unsigned   digit_sum;
    int unsigned   ndigits;
    int unsigned   leading;
    int unsigned   following;
    bit            doubled;
    card_verdict_t r;
    rest      = 64'(number);
    digit_sum = 0;
    ndigits   = 0;
    leading   = 0;
    following = 0;
    doubled   = 1'b0;
    while (rest != 0) begin
      digit = int'(rest % 10);
      rest  = rest / 10;
      if (doubled) begin
        digit_sum += (2 * digit) / 10 + (2 * digit) % 10;
      end else begin
        digit_sum += digit;
      end
      doubled   = !doubled;
      following = leading;
      leading   = digit;
      ndigits++;
    end
    r.checksum_ok  = (digit_sum % 10 == 0);
    r.digit_count  = 5'(ndigits);
    r.out_of_range = (64'(number) < LOW_LIMIT) || (64'(number) >= HIGH_LIMIT);
    r.verdict      = VERDICT_INVALID;
    if (r.checksum_ok && !r.out_of_range) begin
      if (leading == 3 && (following == 4 || following == 7) && ndigits == 15) begin
        r.verdict = VERDICT_AMEX;
      end else if (leading == 4 && (ndigits == 13 || ndigits == 16)) begin
        r.verdict = VERDICT_VISA;
      end else if (leading == 5 && following >= 1 && following <= 5 && ndigits == 16) begin
        r.verdict = VERDICT_MASTERCARD;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pending_card_t exp_card;
    card_verdict_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        exp_card.number = s_tdata[CARD_W-1:0];
        exp_card.result = luhn_predict(s_tdata[CARD_W-1:0]);
        expected_verdicts.push_back(exp_card);
      end
      if (m_tvalid && m_tready) begin
        got.verdict      = m_tdata[1:0];
        got.checksum_ok  = m_tdata[2];
        got.digit_count  = m_tdata[7:3];
        got.out_of_range = m_tdata[8];
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result transfer, m_tdata=%h", m_tdata);
          error_count++;
        end else begin
          exp_card = expected_verdicts.pop_front();
          checked++;
          if (exp_card.result.checksum_ok) luhn_passed++;
          if (exp_card.result.verdict != VERDICT_INVALID) classified++;
          if (got.verdict !== exp_card.result.verdict) begin
            $error("verdict: expected %0d, got %0d (card %0d)",
                   exp_card.result.verdict, got.verdict, exp_card.number);
            error_count++;
          end
          if (got.checksum_ok !== exp_card.result.checksum_ok) begin
            $error("checksum_ok: expected %0d, got %0d (card %0d)",
                   exp_card.result.checksum_ok, got.checksum_ok, exp_card.number);
            error_count++;
          end
          if (got.digit_count !== exp_card.result.digit_count) begin
            $error("digit_count: expected %0d, got %0d (card %0d)",
                   exp_card.result.digit_count, got.digit_count, exp_card.number);
            error_count++;
          end
          if (got.out_of_range !== exp_card.result.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d (card %0d)",
                   exp_card.result.out_of_range, got.out_of_range, exp_card.number);
            error_count++;
          end
        end
      end
      pending = expected_verdicts.size();
    end
  end

endmodule

### test/tb_luhn_card_number_check.sv
// Testbench top for the Luhn card check: clock, reset, card stimulus, flow control, verdict.
`timescale 1ns / 100ps

module tb_luhn_card_number_check;
  import luhn_pkg::*;

  localparam int          RANDOM_CARDS = 1100;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam logic [63:0] LOW_LIMIT    = 64'd1_000_000_000;
  localparam logic [63:0] HIGH_LIMIT   = 64'd10_000_000_000_000_000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;   // [53:0] card_number, [55:54] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [1:0] verdict, [2] checksum_ok, [7:3] digit_count,
                                // [8] out_of_range

  int          error_count;
  int          pending;
  int          checked;
  int          luhn_passed;
  int          classified;
  int          cards_sent   = 0;
  int          cycle_count  = 0;
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 52;

  luhn_card_number_check dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  luhn_verdict_checker verdict_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .error_count (error_count),
    .pending     (pending),
    .checked     (checked),
    .luhn_passed (luhn_passed),
    .classified  (classified)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side back-pressure; the percentage changes per phase.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_luhn_card_number_check: done, errors");
    $finish;
  end

  // Card number of ndigits digits with the given two leading digits, random
  // middle digits, and a check digit that makes the Luhn sum pass or fail.
  function automatic logic [CARD_W-1:0] build_card(int unsigned ndigits, int unsigned leading,
                                                   int unsigned following, bit luhn_good);
    int unsigned d [17];
    int unsigned digit_sum;
    int unsigned check;
    logic [63:0] number;
    digit_sum = 0;
    number    = '0;
    for (int i = 0; i < 17; i++) d[i] = $urandom_range(0, 9);
    d[ndigits-1] = leading;
    d[ndigits-2] = following;
    for (int i = 1; i < int'(ndigits); i++) begin
      if (i % 2 == 1) digit_sum += (2 * d[i]) / 10 + (2 * d[i]) % 10;
      else digit_sum += d[i];
    end
    check = (10 - digit_sum % 10) % 10;
    if (!luhn_good) check = (check + $urandom_range(1, 9)) % 10;
    d[0] = check;
    for (int i = int'(ndigits) - 1; i >= 0; i--) number = number * 10 + d[i];
    return number[CARD_W-1:0];
  endfunction

  // One transfer on the card channel, with random idle cycles ahead of it.
  // s_tvalid stays high from one card to the next when no idle is drawn.
  task automatic send_card(input logic [CARD_W-1:0] number);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, number};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cards_sent++;
  endtask

  // Random card: mostly well-formed numbers of the three card families or
  // near misses, the rest raw 54-bit values, short numbers and range edges.
  task automatic send_random_card();
    int unsigned pick;
    int unsigned ndigits;
    int unsigned following;
    bit          good;
    logic [63:0] raw;
    pick = $urandom_range(0, 99);
    good = ($urandom_range(0, 3) != 0);
    raw  = {$urandom, $urandom};
    if (pick < 16) begin
      send_card(build_card(15, 3, ($urandom_range(0, 1) != 0) ? 4 : 7, good));
    end else if (pick < 32) begin
      send_card(build_card(($urandom_range(0, 1) != 0) ? 13 : 16, 4,
                           $urandom_range(0, 9), good));
    end else if (pick < 48) begin
      send_card(build_card(16, 5, $urandom_range(1, 5), good));
    end else if (pick < 65) begin
      // near misses: any length 9..17, any leading pair below 17 digits
      ndigits = $urandom_range(9, 17);
      if (ndigits == 17) begin
        following = $urandom_range(0, 7);   // keeps 17 digits within 54 bits
        send_card(build_card(ndigits, 1, following, good));
      end else begin
        send_card(build_card(ndigits, $urandom_range(1, 9), $urandom_range(0, 9), good));
      end
    end else if (pick < 80) begin
      send_card(raw[CARD_W-1:0]);
    end else if (pick < 90) begin
      if ($urandom_range(0, 3) == 0) raw = 64'($urandom_range(0, 99));
      else raw = 64'($urandom % 32'd1_000_000_000);
      send_card(raw[CARD_W-1:0]);
    end else begin
      raw = (($urandom_range(0, 1) != 0) ? LOW_LIMIT : HIGH_LIMIT) - 8
            + 64'($urandom_range(0, 15));
      send_card(raw[CARD_W-1:0]);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero, range edges, all-ones, alternating bits, known good
    // numbers of each family, checksum failures and misclassified prefixes.
    send_card(54'd0);
    send_card(54'd1);
    send_card(54'd9);
    send_card(54'd999_999_999);
    send_card(54'd1_000_000_000);
    send_card(54'd9_999_999_999_999_999);
    send_card(54'd10_000_000_000_000_000);
    send_card({CARD_W{1'b1}});
    send_card(54'h2A_AAAA_AAAA_AAAA);
    send_card(54'h15_5555_5555_5555);
    send_card(54'd378_282_246_310_005);         // amex
    send_card(54'd371_449_635_398_431);         // amex, second digit 7
    send_card(54'd4_111_111_111_111_111);       // visa, 16 digits
    send_card(54'd4_222_222_222_222);           // visa, 13 digits
    send_card(54'd5_555_555_555_554_444);       // mastercard
    send_card(54'd5_105_105_105_105_100);       // mastercard, second digit 1
    send_card(54'd4_111_111_111_111_112);       // checksum fails
    send_card(build_card(15, 3, 5, 1'b1));      // amex prefix wrong
    send_card(build_card(16, 3, 4, 1'b1));      // amex prefix, wrong length
    send_card(build_card(16, 5, 6, 1'b1));      // mastercard second digit too high
    send_card(build_card(16, 5, 0, 1'b1));      // mastercard second digit zero
    send_card(build_card(14, 4, 2, 1'b1));      // visa prefix, wrong length
    send_card(build_card(13, 4, 7, 1'b0));      // visa shape, bad check digit
    send_card(build_card(9, 4, 1, 1'b1));       // passes Luhn, below range
    send_card(build_card(17, 1, 7, 1'b1));      // passes Luhn, above range

    // Three flow-control phases: sender idles lightly, then heavily, then neither.
    for (int i = 0; i < RANDOM_CARDS; i++) begin
      if (i == RANDOM_CARDS / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 21;
      end else if (i == 2 * RANDOM_CARDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_card();
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("%0d card numbers sent over three flow-control phases, %0d results compared",
             cards_sent, checked);
    $display("%0d passed the Luhn sum, %0d classified as amex, visa or mastercard",
             luhn_passed, classified);
    if (error_count == 0) begin
      $display("tb_luhn_card_number_check: done, clean");
    end else begin
      $display("tb_luhn_card_number_check: done, errors");
    end
    $finish;
  end

endmodule
